FILE: hdl/rwtc_pkg.sv
`default_nettype none

package rwtc_pkg;

   localparam int KEY_W   = 64;
   localparam int TIME_W  = 32;
   localparam int ACT_W   = 3;
   localparam int SLOT_W  = 4;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 3;

   // result action codes
   localparam logic [ACT_W-1:0] ACT_CHECK   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_REFRESH = 3'd1;
   localparam logic [ACT_W-1:0] ACT_REUSE   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_APPEND  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_EVICT   = 3'd4;

   // item kinds
   localparam logic KIND_CHECK  = 1'b0;
   localparam logic KIND_RECORD = 1'b1;

   // register index of window_ms
   localparam logic REG_WINDOW = 1'b0;

   localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd10000;

   typedef struct packed {
      logic              kind;
      logic [KEY_W-1:0]  token_key;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic             replay;
      logic [ACT_W-1:0] action;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   // lookup word walking down the cell row
   typedef struct packed {
      logic              valid;
      logic              kind;
      logic [KEY_W-1:0]  token_key;
      logic [TIME_W-1:0] now_ms;
      logic              match_found;  // key present in a filled entry
      logic              young_hit;    // key present and inside window
      logic              exp_found;    // some filled entry has expired
      logic              min_valid;    // min_stamp holds a filled entry
      logic [TIME_W-1:0] min_stamp;
   } probe_type;

endpackage

`default_nettype wire

FILE: hdl/rwtc_cell.sv
`default_nettype none

module rwtc_cell
   import rwtc_pkg::*;
#(
   parameter int IDX_W = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [TIME_W-1:0] window,
   input  wire logic [IDX_W-1:0]  cell_idx,
   input  wire logic              filled,
   input  wire probe_type         up_probe,
   input  wire logic [IDX_W-1:0]  up_match_idx,
   input  wire logic [IDX_W-1:0]  up_exp_idx,
   input  wire logic [IDX_W-1:0]  up_min_idx,
   output      probe_type         dn_probe,
   output      logic [IDX_W-1:0]  dn_match_idx,
   output      logic [IDX_W-1:0]  dn_exp_idx,
   output      logic [IDX_W-1:0]  dn_min_idx,
   input  wire logic              wr_en,
   input  wire logic [KEY_W-1:0]  wr_key,
   input  wire logic [TIME_W-1:0] wr_stamp
);

   logic [KEY_W-1:0]  key_ff;
   logic [TIME_W-1:0] stamp_ff;

   probe_type         probe_ff, probe_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   logic [IDX_W-1:0]  exp_idx_ff, exp_idx_in;
   logic [IDX_W-1:0]  min_idx_ff, min_idx_in;

   logic [TIME_W-1:0] age;
   logic              young;
   logic              match;

   always_comb begin
      age          = up_probe.now_ms - stamp_ff;
      young        = age < window;
      match        = filled && (key_ff == up_probe.token_key);
      probe_in     = up_probe;
      match_idx_in = up_match_idx;
      exp_idx_in   = up_exp_idx;
      min_idx_in   = up_min_idx;
      if (match && !up_probe.match_found) begin
         probe_in.match_found = 1'b1;
         match_idx_in         = cell_idx;
      end
      if (match && young) begin
         probe_in.young_hit = 1'b1;
      end
      if (filled && !young && !up_probe.exp_found) begin
         probe_in.exp_found = 1'b1;
         exp_idx_in         = cell_idx;
      end
      // strict less-than keeps the first entry on a tie
      if (filled && (!up_probe.min_valid || stamp_ff < up_probe.min_stamp)) begin
         probe_in.min_valid = 1'b1;
         probe_in.min_stamp = stamp_ff;
         min_idx_in         = cell_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in;
      end
      match_idx_ff <= match_idx_in;
      exp_idx_ff   <= exp_idx_in;
      min_idx_ff   <= min_idx_in;
      if (wr_en) begin
         key_ff   <= wr_key;
         stamp_ff <= wr_stamp;
      end
   end

   assign dn_probe     = probe_ff;
   assign dn_match_idx = match_idx_ff;
   assign dn_exp_idx   = exp_idx_ff;
   assign dn_min_idx   = min_idx_ff;

endmodule

`default_nettype wire

FILE: hdl/replay_window_token_cache_core.sv
`default_nettype none

// Channel  | Ports                                          | Handshake
// ---------+------------------------------------------------+---------------------------------
// request  | start, busy, req_data                          | item taken when start && !busy
// response | rsp_valid, rsp_data                            | one-cycle strobe, no backpressure
// control  | psel penable pwrite paddr pwdata prdata pready | write at psel&penable&pwrite
//
// A new item is taken only once busy has fallen. Each item is latched in the
// head register, then the lookup word walks the cell row through one register
// per cell, and then the chosen entry is resolved and written. The result
// strobe rises in the cycle busy falls. Reset clears the fill count, the window
// register (to 10000) and all handshake state; entry contents need no clearing
// since only filled entries are ever looked at. The response side cannot stall.

module replay_window_token_cache_core
   import rwtc_pkg::*;
#(
   parameter int CACHE_ENTRIES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request
   input  wire logic              start,
   output      logic              busy,
   input  wire req_type           req_data,
   // response
   output      logic              rsp_valid,
   output      rsp_type           rsp_data,
   // control registers
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output      logic [DATA_W-1:0] prdata,
   output      logic              pready
);

   localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(CACHE_ENTRIES);

   logic              busy_ff;
   logic [CNT_W-1:0]  fill_ff;
   logic [TIME_W-1:0] window_ff;
   probe_type         head_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff;

   // lookup word at the entry of each cell, plus the one leaving the row
   probe_type         probe_w     [0:CACHE_ENTRIES];
   logic [IDX_W-1:0]  match_idx_w [0:CACHE_ENTRIES];
   logic [IDX_W-1:0]  exp_idx_w   [0:CACHE_ENTRIES];
   logic [IDX_W-1:0]  min_idx_w   [0:CACHE_ENTRIES];

   logic              accept;
   logic              done;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_slot;
   logic              append;
   logic              csr_write;
   logic              csr_hit;
   probe_type         last;

   assign accept    = start && !busy_ff;
   assign csr_hit   = (paddr[2] == REG_WINDOW);
   assign csr_write = psel && penable && pwrite && csr_hit;

   assign probe_w[0]     = head_ff;
   assign match_idx_w[0] = '0;
   assign exp_idx_w[0]   = '0;
   assign min_idx_w[0]   = '0;

   assign last = probe_w[CACHE_ENTRIES];
   assign done = last.valid;

   // pick the rule that applies once the word has seen every entry
   always_comb begin
      rsp_in  = '0;
      wr_slot = '0;
      append  = 1'b0;
      if (last.kind == KIND_CHECK) begin
         rsp_in.replay = last.young_hit;
         rsp_in.action = ACT_CHECK;
      end else if (last.match_found) begin
         rsp_in.action = ACT_REFRESH;
         wr_slot       = match_idx_w[CACHE_ENTRIES];
      end else if (last.exp_found) begin
         rsp_in.action = ACT_REUSE;
         wr_slot       = exp_idx_w[CACHE_ENTRIES];
      end else if (fill_ff < FULL) begin
         rsp_in.action = ACT_APPEND;
         wr_slot       = fill_ff[IDX_W-1:0];
         append        = 1'b1;
      end else begin
         rsp_in.action = ACT_EVICT;
         wr_slot       = min_idx_w[CACHE_ENTRIES];
      end
      if (last.kind == KIND_RECORD) begin
         rsp_in.slot = SLOT_W'(wr_slot);
      end
   end

   // refresh rewrites the same key, so every record writes key and stamp
   assign wr_en = done && (last.kind == KIND_RECORD);

   for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
      rwtc_cell #(
         .IDX_W(IDX_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .window       (window_ff),
         .cell_idx     (IDX_W'(g)),
         .filled       (CNT_W'(g) < fill_ff),
         .up_probe     (probe_w[g]),
         .up_match_idx (match_idx_w[g]),
         .up_exp_idx   (exp_idx_w[g]),
         .up_min_idx   (min_idx_w[g]),
         .dn_probe     (probe_w[g+1]),
         .dn_match_idx (match_idx_w[g+1]),
         .dn_exp_idx   (exp_idx_w[g+1]),
         .dn_min_idx   (min_idx_w[g+1]),
         .wr_en        (wr_en && (wr_slot == IDX_W'(g))),
         .wr_key       (last.token_key),
         .wr_stamp     (last.now_ms)
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         fill_ff      <= '0;
         window_ff    <= WINDOW_RESET;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // head valid is a one-cycle strobe; the word then moves into the first cell
         head_ff.valid <= accept;
         if (accept) begin
            head_ff.kind        <= req_data.kind;
            head_ff.token_key   <= req_data.token_key;
            head_ff.now_ms      <= req_data.now_ms;
            head_ff.match_found <= 1'b0;
            head_ff.young_hit   <= 1'b0;
            head_ff.exp_found   <= 1'b0;
            head_ff.min_valid   <= 1'b0;
            head_ff.min_stamp   <= '0;
            busy_ff             <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
         rsp_valid_ff <= done;
         if (wr_en && append) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (csr_write) begin
            window_ff <= pwdata;
         end
      end
      if (done) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;
   assign prdata    = csr_hit ? window_ff : '0;

`ifndef NO_ASSERTIONS
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("busy not raised after accepting an item");

   a_result_ends_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff && $past(busy_ff))
      else $error("result strobe outside an item");

   a_busy_falls_with_result : assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> rsp_valid_ff)
      else $error("busy dropped without a result");

   a_fill_bounded : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL)
      else $error("fill count beyond cache size");

   a_append_grows : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.action == ACT_APPEND) |-> fill_ff == $past(fill_ff) + 1'b1)
      else $error("append did not grow the fill count");

   a_check_slot_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.action == ACT_CHECK) |-> rsp_ff.slot == '0)
      else $error("check result with nonzero slot");
`endif

endmodule

`default_nettype wire

FILE: test/replay_window_token_cache_core_tb.sv
`default_nettype none

module replay_window_token_cache_core_tb;
   import rwtc_pkg::*;

   localparam int ENTRIES     = 16;
   localparam int POOL_SIZE   = 24;     // more keys than entries, so the cache overflows
   localparam int PHASE_ITEMS = 246;
   localparam int STALL_LIMIT = 2000;   // cycles with no traffic at all before giving up
   localparam int PRINT_CAP   = 100;

   localparam logic [ADDR_W-1:0] WINDOW_ADDR = ADDR_W'(4 * int'(REG_WINDOW));
   localparam logic [ADDR_W-1:0] SPARE_ADDR  = ADDR_W'(4 * (int'(REG_WINDOW) + 1));

   // ---------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ---------------------------------------------------------------------------
   logic              clock    = 1'b0;
   logic              reset    = 1'b1;
   logic              start    = 1'b0;
   req_type           req_data = '0;
   logic              psel     = 1'b0;
   logic              penable  = 1'b0;
   logic              pwrite   = 1'b0;
   logic [ADDR_W-1:0] paddr    = '0;
   logic [DATA_W-1:0] pwdata   = '0;
   logic              busy;
   logic              rsp_valid;
   rsp_type           rsp_data;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   replay_window_token_cache_core #(
      .CACHE_ENTRIES(ENTRIES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Model of the cache contents and the window register
   // ---------------------------------------------------------------------------
   logic [KEY_W-1:0]  cached_keys   [ENTRIES];
   logic [TIME_W-1:0] cached_stamps [ENTRIES];
   int unsigned       entries_filled = 0;
   logic [TIME_W-1:0] window_len     = WINDOW_RESET;

   // Item traffic and verdict bookkeeping
   req_type           queued_requests[$];
   rsp_type           due_verdicts[$];
   int unsigned       idle_pct       = 38;
   int unsigned       mismatch_count = 0;
   int unsigned       quiet_cycles   = 0;
   logic [KEY_W-1:0]  key_pool [POOL_SIZE];
   logic [TIME_W-1:0] clock_ms = '0;     // stimulus time cursor

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   // One item against the cache: returns the verdict, updates the model.
   // Only the first entries_filled entries are ever looked at.
   function automatic rsp_type token_cache_step(req_type item);
      rsp_type     res;
      int unsigned i;
      int unsigned low;
      logic        placed;
      res    = '0;
      placed = 1'b0;

      if (item.kind == KIND_CHECK) begin
         res.action = ACT_CHECK;
         for (i = 0; i < entries_filled; i++) begin
            // age wraps mod 2^32; a zero window never hits
            if (cached_keys[i] == item.token_key &&
                TIME_W'(item.now_ms - cached_stamps[i]) < window_len)
               res.replay = 1'b1;
         end
         return res;
      end

      // refresh a known key
      for (i = 0; i < entries_filled && !placed; i++) begin
         if (cached_keys[i] == item.token_key) begin
            cached_stamps[i] = item.now_ms;
            res.action = ACT_REFRESH;
            res.slot   = SLOT_W'(i);
            placed     = 1'b1;
         end
      end

      // take over the first expired entry
      for (i = 0; i < entries_filled && !placed; i++) begin
         if (TIME_W'(item.now_ms - cached_stamps[i]) >= window_len) begin
            cached_keys[i]   = item.token_key;
            cached_stamps[i] = item.now_ms;
            res.action = ACT_REUSE;
            res.slot   = SLOT_W'(i);
            placed     = 1'b1;
         end
      end

      // append while there is room
      if (!placed && entries_filled < ENTRIES) begin
         cached_keys[entries_filled]   = item.token_key;
         cached_stamps[entries_filled] = item.now_ms;
         res.action = ACT_APPEND;
         res.slot   = SLOT_W'(entries_filled);
         entries_filled++;
         placed = 1'b1;
      end

      // full and all young: evict the lowest raw stamp, first one on a tie
      if (!placed) begin
         low = 0;
         for (i = 1; i < ENTRIES; i++)
            if (cached_stamps[i] < cached_stamps[low])
               low = i;
         cached_keys[low]   = item.token_key;
         cached_stamps[low] = item.now_ms;
         res.action = ACT_EVICT;
         res.slot   = SLOT_W'(low);
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: offers queued items, predicts each one at the edge it is taken
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      req_type next_req;
      logic    offer;
      offer = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            due_verdicts.push_back(token_cache_step(req_data));
         // free to change the offer unless an item is still waiting on busy
         if (!start || !busy) begin
            offer = queued_requests.size() != 0 && $urandom_range(99) >= idle_pct;
            if (offer) begin
               next_req = queued_requests.pop_front();
               req_data <= next_req;
            end
            start <= offer;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: results cannot be held off, so every strobe is checked as it comes
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (due_verdicts.size() == 0) begin
            report_mismatch($sformatf("result with no item outstanding: %p", rsp_data));
         end else begin
            want = due_verdicts.pop_front();
            if (rsp_data.replay !== want.replay)
               report_mismatch($sformatf("replay %b, want %b", rsp_data.replay, want.replay));
            if (rsp_data.action !== want.action)
               report_mismatch($sformatf("action %0d, want %0d", rsp_data.action, want.action));
            if (rsp_data.slot !== want.slot)
               report_mismatch($sformatf("slot %0d, want %0d", rsp_data.slot, want.slot));
         end
      end
   end

   // Watchdog: any accepted item, result or register access counts as progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1 || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic queue_item(input logic kind, input logic [KEY_W-1:0] key,
                             input logic [TIME_W-1:0] now);
      req_type item;
      item.kind      = kind;
      item.token_key = key;
      item.now_ms    = now;
      queued_requests.push_back(item);
   endtask

   // Random item: mostly pool keys on a time cursor that steps around the window
   // edge, with some arbitrary keys and out-of-order times mixed in.
   function automatic req_type make_traffic_item();
      req_type           item;
      logic [TIME_W-1:0] span;
      span = (window_len == 0) ? TIME_W'(64) : window_len;
      item.kind      = ($urandom_range(99) < 55) ? KIND_RECORD : KIND_CHECK;
      item.token_key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                                  : {$urandom, $urandom};
      if ($urandom_range(99) < 8) begin
         item.now_ms = $urandom;
         return item;
      end
      case ($urandom_range(9))
         0, 1, 2: ;                                       // same ms: stamp ties
         3, 4:    clock_ms = clock_ms + $urandom_range(span / 16);
         5:       clock_ms = clock_ms + span - 1;         // last young ms
         6:       clock_ms = clock_ms + span;             // first expired ms
         7:       clock_ms = clock_ms + span + 1;
         8:       clock_ms = clock_ms + $urandom_range(span / 4);
         default: clock_ms = 32'hFFFF_FFFF - $urandom_range(span / 8);  // just short of wrap
      endcase
      item.now_ms = clock_ms;
      return item;
   endfunction

   // Everything queued, taken and answered
   task automatic wait_for_drain();
      do @(negedge clock);
      while (queued_requests.size() != 0 || start || due_verdicts.size() != 0);
   endtask

   // Setup then access; written at the edge closing the access cycle
   task automatic csr_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (addr == WINDOW_ADDR)
         window_len = data;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // prdata sampled mid access cycle, clear of the closing edge
   task automatic csr_check_window();
      logic [DATA_W-1:0] got;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= WINDOW_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      got = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== window_len)
         report_mismatch($sformatf("window reads %h, want %h", got, window_len));
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      logic [TIME_W-1:0] phase_window [6];
      int unsigned       p;
      int unsigned       n;

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (n = 2; n < POOL_SIZE; n++)
         key_pool[n] = {$urandom, $urandom};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_check_window();                       // reset value of the window

      // Directed part, window at its reset value of 10000
      queue_item(KIND_CHECK,  64'h0, 32'h0);            // empty cache: nothing to hit
      queue_item(KIND_RECORD, 64'h0, 32'hFFFF_FFF0);    // append near the wrap
      queue_item(KIND_CHECK,  64'h0, 32'h0000_0005);    // age spans the wrap, still young
      queue_item(KIND_CHECK,  64'h0, 32'd9983);         // age 9999: last young ms
      queue_item(KIND_CHECK,  64'h0, 32'd9984);         // age 10000: just out of window
      queue_item(KIND_RECORD, 64'h0, 32'd9983);         // refresh
      for (n = 1; n < ENTRIES; n++)                      // fill up; entries 1 and 2 share a stamp
         queue_item(KIND_RECORD, (n == ENTRIES - 1) ? '1 : 64'h1 << (4 * n),
                    (n <= 2) ? 32'd10000 : 32'd10000 + n);
      queue_item(KIND_RECORD, 64'h0, 32'd10030);        // refresh entry 0 past the tied pair
      queue_item(KIND_RECORD, 64'hA5A5_5A5A_F00F_0FF0, 32'd10040);  // full: evict, tie -> first
      queue_item(KIND_CHECK,  64'h1 << 4, 32'd10041);   // evicted key is gone
      queue_item(KIND_RECORD, 64'h8000_0000_0000_0000, 32'd20020);  // first expired entry reused
      wait_for_drain();

      // A write to an unused register index must leave the window alone
      csr_write(SPARE_ADDR, $urandom);
      csr_check_window();

      // Random phases over window settings, extremes first; one phase runs
      // with the sender never idling
      phase_window[0] = 32'd1;
      phase_window[1] = 32'd0;
      phase_window[2] = 32'hFFFF_FFFF;
      phase_window[3] = $urandom;
      phase_window[4] = WINDOW_RESET;
      phase_window[5] = $urandom_range(5000, 20);
      for (p = 0; p < 6; p++) begin
         csr_write(WINDOW_ADDR, phase_window[p]);
         csr_check_window();
         idle_pct = (p == 2) ? 0 : 38;
         @(negedge clock);
         for (n = 0; n < PHASE_ITEMS; n++)
            queued_requests.push_back(make_traffic_item());
         // sender holds off until every verdict is back before the next write
         wait_for_drain();
      end

      repeat (2 * (ENTRIES + 2)) @(posedge clock);
      if (due_verdicts.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", due_verdicts.size()));
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
hdl/rwtc_pkg.sv
hdl/rwtc_cell.sv
hdl/replay_window_token_cache_core.sv
test/replay_window_token_cache_core_tb.sv
